@@ rtl/cidr_pkg.sv @@
// ----------------------------------------------------------------------------
// cidr_pkg
// Shared types and constants for the IPv4 CIDR text parser and subnet
// calculator.
// ----------------------------------------------------------------------------
package cidr_pkg;

	// text character codes
	localparam logic [7:0] CH_DOT   = 8'd46;
	localparam logic [7:0] CH_SLASH = 8'd47;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;

	// parse limits
	localparam logic [9:0] OCTET_MAX      = 10'd255;
	localparam logic [5:0] PREFIX_MAX     = 6'd32;
	localparam logic [5:0] PREFIX_SAT     = 6'd33;
	localparam logic [5:0] PREFIX_HOST31  = 6'd31;
	localparam logic [1:0] LAST_OCTET     = 2'd3;
	localparam logic [1:0] MAX_DIGITS     = 2'd3;

	// configuration register map
	localparam int         PADDR_W            = 3;
	localparam logic [2:0] ADDR_REQUIRE_PREFIX = 3'd0;
	localparam logic       REQUIRE_PREFIX_RST  = 1'b1;

	// parser phase
	typedef enum logic [1:0] {
		PH_LEAD,
		PH_BODY,
		PH_TRAIL
	} phase_t;

	// one input item
	typedef struct packed {
		logic [7:0] char_code;
		logic       has_char;
		logic       end_of_text;
	} item_t;

	// parse outcome at end of text
	typedef struct packed {
		logic        ok;
		logic [31:0] address;
		logic [5:0]  prefix;
	} fin_t;

	// one result item
	typedef struct packed {
		logic        valid_res;
		logic [31:0] address;
		logic [5:0]  prefix_len;
		logic [31:0] net_mask;
		logic [31:0] wild_mask;
		logic [31:0] network_addr;
		logic [31:0] broadcast_addr;
		logic [31:0] first_host;
		logic [31:0] last_host;
		logic [31:0] usable_hosts;
		logic [8:0]  block_size;
		logic [2:0]  focus_octet;
	} res_t;

endpackage

@@ rtl/cidr_text_if.sv @@
// ----------------------------------------------------------------------------
// cidr_text_if
// Character channel: one byte of address text per transfer.
// ----------------------------------------------------------------------------
interface cidr_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       has_char;
	logic       end_of_text;

	modport source (output valid, output char_code, output has_char,
		output end_of_text, input ready);
	modport sink (input valid, input char_code, input has_char,
		input end_of_text, output ready);
endinterface

@@ rtl/cidr_res_if.sv @@
// ----------------------------------------------------------------------------
// cidr_res_if
// Result channel: one subnet calculation per transfer.
// ----------------------------------------------------------------------------
interface cidr_res_if;
	logic        valid;
	logic        ready;
	logic        valid_res;
	logic [31:0] address;
	logic [5:0]  prefix_len;
	logic [31:0] net_mask;
	logic [31:0] wild_mask;
	logic [31:0] network_addr;
	logic [31:0] broadcast_addr;
	logic [31:0] first_host;
	logic [31:0] last_host;
	logic [31:0] usable_hosts;
	logic [8:0]  block_size;
	logic [2:0]  focus_octet;

	modport source (output valid, output valid_res, output address, output prefix_len,
		output net_mask, output wild_mask, output network_addr, output broadcast_addr,
		output first_host, output last_host, output usable_hosts, output block_size,
		output focus_octet, input ready);
	modport sink (input valid, input valid_res, input address, input prefix_len,
		input net_mask, input wild_mask, input network_addr, input broadcast_addr,
		input first_host, input last_host, input usable_hosts, input block_size,
		input focus_octet, output ready);
endinterface

@@ rtl/cidr_parse.sv @@
// ----------------------------------------------------------------------------
// cidr_parse
// Character step of the dotted-quad / prefix parser. Holds the running parse
// state and gives the parse outcome for an end-of-text item.
// ----------------------------------------------------------------------------
module cidr_parse (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  cidr_pkg::item_t item,
	input  logic            require_prefix,
	output cidr_pkg::fin_t  fin
);

	cidr_pkg::phase_t phase_q, phase_n;
	logic [1:0]  oct_idx_q, oct_idx_n;
	logic [1:0]  dcnt_q, dcnt_n;
	logic [9:0]  oct_q, oct_n;
	logic [31:0] acc_q, acc_n;
	logic        slash_q, slash_n;
	logic [5:0]  pfx_q, pfx_n;
	logic        pdig_q, pdig_n;
	logic        err_q, err_n;

	logic        ws, dig;
	logic [3:0]  dval;
	logic [9:0]  oct_x10;
	logic [8:0]  pfx_x10;

	// character class
	always_comb begin
		ws   = (item.char_code == cidr_pkg::CH_SPACE) ||
			(item.char_code inside {[cidr_pkg::CH_TAB:cidr_pkg::CH_CR]});
		dig  = item.char_code inside {[cidr_pkg::CH_ZERO:cidr_pkg::CH_NINE]};
		dval = 4'(item.char_code - cidr_pkg::CH_ZERO);
		oct_x10 = {oct_q[6:0], 3'b000} + {oct_q[8:0], 1'b0} + 10'(dval);
		pfx_x10 = {pfx_q, 3'b000} + {2'b00, pfx_q, 1'b0} + 9'(dval);
	end

	// next phase
	always_comb begin
		phase_n = phase_q;
		if (item.has_char) begin
			case (phase_q)
				cidr_pkg::PH_LEAD:  phase_n = ws ? cidr_pkg::PH_LEAD : cidr_pkg::PH_BODY;
				cidr_pkg::PH_BODY:  phase_n = ws ? cidr_pkg::PH_TRAIL : cidr_pkg::PH_BODY;
				cidr_pkg::PH_TRAIL: phase_n = cidr_pkg::PH_TRAIL;
				default:            phase_n = phase_q;
			endcase
		end
	end

	// octet and prefix accumulation
	always_comb begin
		oct_idx_n = oct_idx_q;
		dcnt_n    = dcnt_q;
		oct_n     = oct_q;
		acc_n     = acc_q;
		slash_n   = slash_q;
		pfx_n     = pfx_q;
		pdig_n    = pdig_q;
		err_n     = err_q;
		// non-space after trailing whitespace
		if (item.has_char && phase_q == cidr_pkg::PH_TRAIL && !ws)
			err_n = 1'b1;
		if (item.has_char && phase_q != cidr_pkg::PH_TRAIL && !ws && !err_q) begin
			if (!slash_q) begin
				if (dig) begin
					if (dcnt_q >= cidr_pkg::MAX_DIGITS) begin
						err_n = 1'b1;
					end else begin
						oct_n  = oct_x10;
						dcnt_n = dcnt_q + 2'd1;
					end
				end else if (item.char_code == cidr_pkg::CH_DOT) begin
					if (dcnt_q == 2'd0 || oct_idx_q >= cidr_pkg::LAST_OCTET) begin
						err_n = 1'b1;
					end else begin
						if (oct_q > cidr_pkg::OCTET_MAX)
							err_n = 1'b1;
						acc_n     = {acc_q[23:0], oct_q[7:0]};
						oct_n     = '0;
						dcnt_n    = '0;
						oct_idx_n = oct_idx_q + 2'd1;
					end
				end else if (item.char_code == cidr_pkg::CH_SLASH) begin
					if (dcnt_q == 2'd0 || oct_idx_q != cidr_pkg::LAST_OCTET) begin
						err_n = 1'b1;
					end else begin
						if (oct_q > cidr_pkg::OCTET_MAX)
							err_n = 1'b1;
						acc_n   = {acc_q[23:0], oct_q[7:0]};
						oct_n   = '0;
						dcnt_n  = '0;
						slash_n = 1'b1;
					end
				end else begin
					err_n = 1'b1;
				end
			end else begin
				if (dig) begin
					pdig_n = 1'b1;
					pfx_n  = (pfx_x10 > 9'(cidr_pkg::PREFIX_MAX)) ? cidr_pkg::PREFIX_SAT
						: pfx_x10[5:0];
				end else begin
					err_n = 1'b1;
				end
			end
		end
	end

	// end-of-text checks on the updated state
	always_comb begin
		fin.ok      = !err_n && (phase_n != cidr_pkg::PH_LEAD);
		fin.address = acc_n;
		fin.prefix  = cidr_pkg::PREFIX_MAX;
		if (!slash_n) begin
			if (oct_idx_n != cidr_pkg::LAST_OCTET || dcnt_n == 2'd0 || require_prefix)
				fin.ok = 1'b0;
			if (oct_n > cidr_pkg::OCTET_MAX)
				fin.ok = 1'b0;
			fin.address = {acc_n[23:0], oct_n[7:0]};
		end else if (pdig_n) begin
			if (pfx_n > cidr_pkg::PREFIX_MAX)
				fin.ok = 1'b0;
			else
				fin.prefix = pfx_n;
		end else if (require_prefix) begin
			fin.ok = 1'b0;
		end
	end

	// parse state, cleared after each end of text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= cidr_pkg::PH_LEAD;
			oct_idx_q <= '0;
			dcnt_q    <= '0;
			oct_q     <= '0;
			acc_q     <= '0;
			slash_q   <= 1'b0;
			pfx_q     <= '0;
			pdig_q    <= 1'b0;
			err_q     <= 1'b0;
		end else if (go) begin
			if (item.end_of_text) begin
				phase_q   <= cidr_pkg::PH_LEAD;
				oct_idx_q <= '0;
				dcnt_q    <= '0;
				oct_q     <= '0;
				acc_q     <= '0;
				slash_q   <= 1'b0;
				pfx_q     <= '0;
				pdig_q    <= 1'b0;
				err_q     <= 1'b0;
			end else begin
				phase_q   <= phase_n;
				oct_idx_q <= oct_idx_n;
				dcnt_q    <= dcnt_n;
				oct_q     <= oct_n;
				acc_q     <= acc_n;
				slash_q   <= slash_n;
				pfx_q     <= pfx_n;
				pdig_q    <= pdig_n;
				err_q     <= err_n;
			end
		end
	end

endmodule

@@ rtl/cidr_calc.sv @@
// ----------------------------------------------------------------------------
// cidr_calc
// Subnet arithmetic: masks, network, broadcast, host range and counts from
// a parsed address and prefix. Fields are zero for a rejected text.
// ----------------------------------------------------------------------------
module cidr_calc (
	input  cidr_pkg::fin_t fin,
	output cidr_pkg::res_t res
);

	logic [31:0] mask, wild, net, bc;
	logic        p32, p31;

	// masks and range ends
	always_comb begin
		mask = ~(32'hFFFF_FFFF >> fin.prefix);
		wild = ~mask;
		net  = fin.address & mask;
		bc   = net | wild;
		p32  = (fin.prefix == cidr_pkg::PREFIX_MAX);
		p31  = (fin.prefix == cidr_pkg::PREFIX_HOST31);
	end

	// result fields
	always_comb begin
		res = '0;
		if (fin.ok) begin
			res.valid_res      = 1'b1;
			res.address        = fin.address;
			res.prefix_len     = fin.prefix;
			res.net_mask       = mask;
			res.wild_mask      = wild;
			res.network_addr   = net;
			res.broadcast_addr = bc;
			res.focus_octet    = p32 ? 3'd4 : ({1'b0, fin.prefix[4:3]} + 3'd1);
			if (p32)
				res.block_size = 9'd1;
			else if (fin.prefix[2:0] == 3'd0)
				res.block_size = 9'd256;
			else
				res.block_size = 9'd1 << (4'd8 - {1'b0, fin.prefix[2:0]});
			if (p32) begin
				res.usable_hosts = 32'd1;
				res.first_host   = fin.address;
				res.last_host    = fin.address;
			end else if (p31) begin
				res.usable_hosts = 32'd2;
				res.first_host   = net;
				res.last_host    = bc;
			end else begin
				// wildcard is 2^host_bits - 1
				res.usable_hosts = wild - 32'd1;
				res.first_host   = net + 32'd1;
				res.last_host    = bc - 32'd1;
			end
		end
	end

endmodule

@@ rtl/ipv4_cidr_text_subnet_calculator.sv @@
// ----------------------------------------------------------------------------
// ipv4_cidr_text_subnet_calculator
// Address text in one character per transfer, one subnet result out per
// end-of-text mark. A character can be taken in every cycle unless an
// end-of-text item waits for room; a result passes through the input,
// parse outcome and result registers. The sustained rate, set by the parse
// state update, is one character per cycle while the result side keeps up.
// Items without an end mark give no result; only an end-of-text item in the
// input register waits for room on the result side, and items behind it wait.
// ----------------------------------------------------------------------------
module ipv4_cidr_text_subnet_calculator (
	input  logic                                clk,
	input  logic                                arst_n,
	cidr_text_if.sink                           text,
	cidr_res_if.source                          result,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [cidr_pkg::PADDR_W-1:0]        paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	logic            require_prefix_q;
	logic            valid_s1;
	cidr_pkg::item_t item_s1;
	logic            valid_s2;
	cidr_pkg::fin_t  fin_s2;
	logic            out_v_q;
	cidr_pkg::res_t  res_q;

	cidr_pkg::fin_t  fin;
	cidr_pkg::res_t  res;
	logic            adv_out, s2_free, s1_go;

	// configuration register
	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		if (paddr == cidr_pkg::ADDR_REQUIRE_PREFIX)
			prdata = {31'b0, require_prefix_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			require_prefix_q <= cidr_pkg::REQUIRE_PREFIX_RST;
		end else if (psel && penable && pwrite && pready &&
			paddr == cidr_pkg::ADDR_REQUIRE_PREFIX) begin
			require_prefix_q <= pwdata[0];
		end
	end

	// flow control: only end-of-text items need room downstream
	assign adv_out    = !out_v_q || result.ready;
	assign s2_free    = !valid_s2 || adv_out;
	assign s1_go      = valid_s1 && (!item_s1.end_of_text || s2_free);
	assign text.ready = !valid_s1 || s1_go;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (text.ready)
			valid_s1 <= text.valid;
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			item_s1.char_code   <= text.char_code;
			item_s1.has_char    <= text.has_char;
			item_s1.end_of_text <= text.end_of_text;
		end
	end

	cidr_parse u_parse (
		.clk            (clk),
		.arst_n         (arst_n),
		.go             (s1_go),
		.item           (item_s1),
		.require_prefix (require_prefix_q),
		.fin            (fin)
	);

	// parse outcome register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (s1_go && item_s1.end_of_text)
			valid_s2 <= 1'b1;
		else if (adv_out)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_go && item_s1.end_of_text)
			fin_s2 <= fin;
	end

	cidr_calc u_calc (
		.fin (fin_s2),
		.res (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (adv_out)
			out_v_q <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s2)
			res_q <= res;
	end

	// result channel
	assign result.valid          = out_v_q;
	assign result.valid_res      = res_q.valid_res;
	assign result.address        = res_q.address;
	assign result.prefix_len     = res_q.prefix_len;
	assign result.net_mask       = res_q.net_mask;
	assign result.wild_mask      = res_q.wild_mask;
	assign result.network_addr   = res_q.network_addr;
	assign result.broadcast_addr = res_q.broadcast_addr;
	assign result.first_host     = res_q.first_host;
	assign result.last_host      = res_q.last_host;
	assign result.usable_hosts   = res_q.usable_hosts;
	assign result.block_size     = res_q.block_size;
	assign result.focus_octet    = res_q.focus_octet;

`ifndef ASSERT_OFF
	// a rejected text carries zero address, net mask and block size
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !res_q.valid_res) |-> (res_q.address == 32'd0 &&
		res_q.net_mask == 32'd0 && res_q.block_size == 9'd0))
		else $error("rejected result has nonzero fields");

	// an accepted text has a legal prefix and matching masks
	a_prefix_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && res_q.valid_res) |-> (res_q.prefix_len <= cidr_pkg::PREFIX_MAX &&
		res_q.wild_mask == ~res_q.net_mask))
		else $error("bad prefix or mask in result");

	// a result follows every buffered end of text when the sink is free
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && adv_out) |=> out_v_q)
		else $error("buffered result lost");

	// a held result only moves on when taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !result.ready) |=> (out_v_q && $stable(res_q)))
		else $error("result changed while stalled");
`endif

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IPv4 CIDR text subnet calculator. Address text
// is fed one character per transfer, an in-bench parser predicts each result
// at every end-of-text transfer, and results are compared field by field in
// order. Runs directed texts, then random well-formed and broken texts under
// both settings of require_prefix and several idle/stall patterns.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int STALL_LIMIT = 2000;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [cidr_pkg::PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	cidr_text_if chars();
	cidr_res_if  results();

	ipv4_cidr_text_subnet_calculator dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.text    (chars),
		.result  (results),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// stimulus and predicted results
	cidr_pkg::item_t  pending_chars[$];
	cidr_pkg::res_t   predicted_subnets[$];
	cidr_pkg::item_t  offered;
	int     items_queued;
	int     send_idle_pct;
	int     recv_idle_pct;
	int     recv_hold;
	int     fail_count;
	int     n_chars;
	int     n_valid;
	int     n_invalid;
	int     quiet_cycles;

	// parser copy, same register and state as the block
	logic       req_prefix_cfg;
	cidr_pkg::phase_t ps_phase;
	logic [1:0] oct_idx;
	logic [1:0] dig_cnt;
	logic [9:0] oct_val;
	logic [31:0] addr_acc;
	logic       slash_seen;
	logic [5:0] pfx_acc;
	logic       pfx_dig_seen;
	logic       parse_err;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void clear_parse();
		ps_phase     = cidr_pkg::PH_LEAD;
		oct_idx      = '0;
		dig_cnt      = '0;
		oct_val      = '0;
		addr_acc     = '0;
		slash_seen   = 1'b0;
		pfx_acc      = '0;
		pfx_dig_seen = 1'b0;
		parse_err    = 1'b0;
	endfunction

	// shift a finished octet into the address
	function automatic void close_octet();
		if (oct_val > cidr_pkg::OCTET_MAX)
			parse_err = 1'b1;
		addr_acc = {addr_acc[23:0], oct_val[7:0]};
		oct_val  = '0;
		dig_cnt  = '0;
	endfunction

	function automatic void parse_char(input logic [7:0] c);
		logic       ws;
		logic       dig;
		logic [3:0] d;
		int         v;
		ws  = (c == cidr_pkg::CH_SPACE) || (c >= cidr_pkg::CH_TAB && c <= cidr_pkg::CH_CR);
		dig = (c >= cidr_pkg::CH_ZERO) && (c <= cidr_pkg::CH_NINE);
		d   = 4'(c - cidr_pkg::CH_ZERO);
		if (ps_phase == cidr_pkg::PH_LEAD) begin
			if (ws)
				return;
			ps_phase = cidr_pkg::PH_BODY;
		end
		// anything but whitespace after the trailing gap is an error
		if (ps_phase == cidr_pkg::PH_TRAIL) begin
			if (!ws)
				parse_err = 1'b1;
			return;
		end
		if (ws) begin
			ps_phase = cidr_pkg::PH_TRAIL;
			return;
		end
		if (parse_err)
			return;
		if (!slash_seen) begin
			if (dig) begin
				if (dig_cnt >= cidr_pkg::MAX_DIGITS) begin
					parse_err = 1'b1;
				end else begin
					oct_val = 10'(int'(oct_val) * 10 + int'(d));
					dig_cnt++;
				end
			end else if (c == cidr_pkg::CH_DOT) begin
				if (dig_cnt == 0 || oct_idx >= cidr_pkg::LAST_OCTET) begin
					parse_err = 1'b1;
				end else begin
					close_octet();
					oct_idx++;
				end
			end else if (c == cidr_pkg::CH_SLASH) begin
				if (dig_cnt == 0 || oct_idx != cidr_pkg::LAST_OCTET) begin
					parse_err = 1'b1;
				end else begin
					close_octet();
					slash_seen = 1'b1;
				end
			end else begin
				parse_err = 1'b1;
			end
		end else if (dig) begin
			// prefix saturates just above the legal range
			v = int'(pfx_acc) * 10 + int'(d);
			pfx_dig_seen = 1'b1;
			pfx_acc = (v > 32) ? cidr_pkg::PREFIX_SAT : 6'(v);
		end else begin
			parse_err = 1'b1;
		end
	endfunction

	// subnet result for the text parsed so far
	function automatic cidr_pkg::res_t subnet_of_text();
		cidr_pkg::res_t r;
		logic        ok;
		int          p;
		logic [31:0] mask;
		logic [63:0] hosts;
		r  = '0;
		ok = !parse_err && (ps_phase != cidr_pkg::PH_LEAD);
		p  = 32;
		if (ok && !slash_seen) begin
			if (oct_idx != cidr_pkg::LAST_OCTET || dig_cnt == 0 || req_prefix_cfg)
				ok = 1'b0;
			else
				close_octet();
			if (parse_err)
				ok = 1'b0;
		end else if (ok) begin
			if (pfx_dig_seen) begin
				if (pfx_acc > cidr_pkg::PREFIX_MAX)
					ok = 1'b0;
				else
					p = int'(pfx_acc);
			end else if (req_prefix_cfg) begin
				ok = 1'b0;
			end
		end
		if (!ok)
			return r;
		mask = (p == 0) ? '0 : (32'hFFFF_FFFF << (32 - p));
		r.valid_res      = 1'b1;
		r.address        = addr_acc;
		r.prefix_len     = 6'(p);
		r.net_mask       = mask;
		r.wild_mask      = ~mask;
		r.network_addr   = addr_acc & mask;
		r.broadcast_addr = r.network_addr | ~mask;
		r.focus_octet    = (p == 32) ? 3'd4 : 3'(p / 8 + 1);
		if (p == 32)
			r.block_size = 9'd1;
		else if (p % 8 == 0)
			r.block_size = 9'd256;
		else
			r.block_size = 9'(1 << (8 - p % 8));
		// host range, /31 and /32 have their own rules
		if (p == cidr_pkg::PREFIX_MAX) begin
			r.usable_hosts = 32'd1;
			r.first_host   = addr_acc;
			r.last_host    = addr_acc;
		end else if (p == cidr_pkg::PREFIX_HOST31) begin
			r.usable_hosts = 32'd2;
			r.first_host   = r.network_addr;
			r.last_host    = r.broadcast_addr;
		end else begin
			hosts          = (64'd1 << (32 - p)) - 64'd2;
			r.usable_hosts = hosts[31:0];
			r.first_host   = r.network_addr + 32'd1;
			r.last_host    = r.broadcast_addr - 32'd1;
		end
		return r;
	endfunction

	function automatic void parse_step(input cidr_pkg::item_t it);
		if (it.has_char)
			parse_char(it.char_code);
		if (it.end_of_text) begin
			predicted_subnets = {predicted_subnets, subnet_of_text()};
			clear_parse();
		end
	endfunction

	function automatic logic [7:0] ws_char();
		int r;
		r = $urandom_range(5);
		return (r == 5) ? cidr_pkg::CH_SPACE : cidr_pkg::CH_TAB + 8'(r);
	endfunction

	// queue a text, end mark on the last char or as a bare item
	task automatic push_chars(input logic [7:0] t[$], input bit sep_end);
		cidr_pkg::item_t it;
		for (int i = 0; i < t.size(); i++) begin
			// ignored filler item now and then
			if ($urandom_range(15) == 0) begin
				it.char_code   = 8'($urandom);
				it.has_char    = 1'b0;
				it.end_of_text = 1'b0;
				pending_chars  = {pending_chars, it};
			end
			it.char_code   = t[i];
			it.has_char    = 1'b1;
			it.end_of_text = !sep_end && (i == t.size() - 1);
			pending_chars  = {pending_chars, it};
			items_queued++;
		end
		if (sep_end || t.size() == 0) begin
			it.char_code   = 8'($urandom);
			it.has_char    = 1'b0;
			it.end_of_text = 1'b1;
			pending_chars  = {pending_chars, it};
			items_queued++;
		end
	endtask

	task automatic push_str(input string s, input bit sep_end);
		logic [7:0] t[$];
		for (int i = 0; i < s.len(); i++)
			t = {t, s[i]};
		push_chars(t, sep_end);
	endtask

	// mostly well-formed cidr text, sometimes broken
	task automatic push_random_text();
		string      s;
		logic [7:0] t[$];
		int         v;
		int         pos;
		s = "";
		if ($urandom_range(39) == 0) begin
			repeat ($urandom_range(6))
				t = {t, 8'($urandom)};
			push_chars(t, 1'($urandom_range(1)));
			return;
		end
		repeat ($urandom_range(2))
			t = {t, ws_char()};
		for (int o = 0; o < 4; o++) begin
			case ($urandom_range(39))
				0: v = 0;
				1: v = 255;
				2: v = $urandom_range(999, 256);
				default: v = $urandom_range(255);
			endcase
			s = {s, ($urandom_range(7) == 0) ? $sformatf("%03d", v) : $sformatf("%0d", v)};
			if (o < 3)
				s = {s, "."};
		end
		case ($urandom_range(19))
			0, 1: ;
			2: s = {s, "/"};
			3: s = {s, $sformatf("/%0d", $urandom_range(99, 33))};
			4: s = {s, $sformatf("/%04d", $urandom_range(32))};
			5: s = {s, $sformatf("/%0d", $urandom_range(99999, 100))};
			6: s = {s, "/0"};
			7: s = {s, "/31"};
			8: s = {s, "/32"};
			default: s = {s, $sformatf("/%0d", $urandom_range(32))};
		endcase
		for (int i = 0; i < s.len(); i++)
			t = {t, s[i]};
		repeat ($urandom_range(2))
			t = {t, ws_char()};
		// corrupt one spot
		if ($urandom_range(7) == 0) begin
			pos = $urandom_range(t.size() - 1);
			case ($urandom_range(3))
				0: t[pos] = 8'($urandom);
				1: t.delete(pos);
				2: t.insert(pos, 8'($urandom));
				default: t.insert(pos, ws_char());
			endcase
		end
		push_chars(t, $urandom_range(3) == 0);
	endtask

	task automatic add_random(input int n);
		int target;
		target = items_queued + n;
		while (items_queued < target)
			push_random_text();
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("mismatch on %s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	// apb write, setup then access, then read back
	task automatic reg_write(input logic [cidr_pkg::PADDR_W-1:0] addr,
			input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == cidr_pkg::ADDR_REQUIRE_PREFIX)
			req_prefix_cfg = data[0];
		@(negedge clk);
		check_field("pready", 32'd1, {31'b0, pready});
		if (addr == cidr_pkg::ADDR_REQUIRE_PREFIX)
			check_field("require_prefix", {31'b0, data[0]}, prdata);
	endtask

	// wait until every text is sent and every result has come back
	task automatic settle();
		while (pending_chars.size() != 0 || chars.valid || predicted_subnets.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// character driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars.valid       <= 1'b0;
			chars.char_code   <= '0;
			chars.has_char    <= 1'b0;
			chars.end_of_text <= 1'b0;
		end else begin
			if (chars.valid && chars.ready) begin
				parse_step(offered);
				n_chars++;
			end
			if (!chars.valid || chars.ready) begin
				if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered = pending_chars.pop_front();
					chars.valid       <= 1'b1;
					chars.char_code   <= offered.char_code;
					chars.has_char    <= offered.has_char;
					chars.end_of_text <= offered.end_of_text;
				end else begin
					chars.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and ready control
	always @(posedge clk or negedge arst_n) begin : result_mon
		cidr_pkg::res_t want;
		if (!arst_n) begin
			results.ready <= 1'b0;
		end else begin
			if (results.valid && results.ready) begin
				if (predicted_subnets.size() == 0) begin
					$error("result transfer with no text ended");
					fail_count++;
				end else begin
					want = predicted_subnets.pop_front();
					check_field("valid_res", 32'(want.valid_res), 32'(results.valid_res));
					check_field("address", want.address, results.address);
					check_field("prefix_len", 32'(want.prefix_len), 32'(results.prefix_len));
					check_field("net_mask", want.net_mask, results.net_mask);
					check_field("wild_mask", want.wild_mask, results.wild_mask);
					check_field("network_addr", want.network_addr, results.network_addr);
					check_field("broadcast_addr", want.broadcast_addr,
						results.broadcast_addr);
					check_field("first_host", want.first_host, results.first_host);
					check_field("last_host", want.last_host, results.last_host);
					check_field("usable_hosts", want.usable_hosts, results.usable_hosts);
					check_field("block_size", 32'(want.block_size), 32'(results.block_size));
					check_field("focus_octet", 32'(want.focus_octet),
						32'(results.focus_octet));
					if (want.valid_res)
						n_valid++;
					else
						n_invalid++;
				end
			end
			if (recv_hold > 0) begin
				results.ready <= 1'b0;
				recv_hold--;
			end else begin
				results.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (chars.valid && chars.ready) || (results.valid && results.ready)
				|| psel) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		clear_parse();
		req_prefix_cfg    = cidr_pkg::REQUIRE_PREFIX_RST;
		arst_n            = 1'b0;
		chars.valid       = 1'b0;
		chars.char_code   = '0;
		chars.has_char    = 1'b0;
		chars.end_of_text = 1'b0;
		results.ready     = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		items_queued      = 0;
		recv_hold         = 0;
		fail_count        = 0;
		n_chars           = 0;
		n_valid           = 0;
		n_invalid         = 0;
		quiet_cycles      = 0;
		send_idle_pct     = 35;
		recv_idle_pct     = 85;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed texts with the prefix required
		reg_write(cidr_pkg::ADDR_REQUIRE_PREFIX, 32'd1);
		push_str("10.44.199.3/20", 1'b0);
		push_str("0.0.0.0/0", 1'b1);
		push_str("255.255.255.255/32", 1'b0);
		push_str("192.168.1.7/31", 1'b0);
		push_str("10.1.2.3/16", 1'b1);
		push_str("\011 \01210.0.0.1/8\015 \013\014", 1'b0);
		push_str("", 1'b1);
		push_str("\011  ", 1'b0);
		push_str("1.2.3.4", 1'b0);
		push_str("1.2.3.4/", 1'b1);
		push_str("1.2.3.4/33", 1'b0);
		push_str("001.002.003.004/0032", 1'b0);
		push_str("9.9.9.9/999999", 1'b0);
		push_str("256.1.1.1/8", 1'b0);
		push_str("1.2.3.1000/8", 1'b0);
		push_str("1..2.3/8", 1'b0);
		push_str("1.2.3.4.5/8", 1'b0);
		push_str("1.2.3/8", 1'b0);
		push_str("1.2 .3.4/8", 1'b0);
		push_str("1.2.3.4/8 x", 1'b0);
		push_str("1.2.3.4/1/2", 1'b0);
		push_str("1.2.3.4/2a", 1'b0);
		push_str("a1.2.3.4/8", 1'b0);
		settle();

		// prefix optional
		reg_write(cidr_pkg::ADDR_REQUIRE_PREFIX, 32'd0);
		push_str("1.2.3.4", 1'b0);
		push_str("1.2.3.4/", 1'b1);
		push_str(" 8.8.4.4 ", 1'b1);
		push_str("1.2.3", 1'b0);
		add_random(120);
		settle();

		// slow sender, busy consumer, idle mixes swapped
		send_idle_pct = 85;
		recv_idle_pct = 35;
		reg_write(cidr_pkg::ADDR_REQUIRE_PREFIX, 32'd1);
		add_random(120);
		settle();

		// full rate, with one long result stall up front
		send_idle_pct = 0;
		recv_idle_pct = 0;
		reg_write(cidr_pkg::ADDR_REQUIRE_PREFIX, 32'd0);
		add_random(120);
		recv_hold = 400;
		settle();

		$display("tb: %0d chars sent, %0d texts checked (%0d valid, %0d rejected)",
			n_chars, n_valid + n_invalid, n_valid, n_invalid);
		$display("tb: require_prefix 0 and 1, idle and stall mixes, long result stall");
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
